@@ rtl/core/dhb_pkg.sv @@
// shared types, codes and constants for the dual h-bridge drive block
`default_nettype none

package dhb_pkg;

   // field widths
   localparam int KIND_W   = 3;
   localparam int MOTOR_W  = 8;
   localparam int VALUE_W  = 16;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 16;
   localparam int DEAD_W   = 8;
   localparam int CMP_W    = 17;
   localparam int MAG_W    = 10;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_TIME  = 1'd1;
   localparam logic [PERIOD_W-1:0]    PWM_PERIOD_RESET = 16'd999;
   localparam logic [DEAD_W-1:0]      DEAD_TIME_RESET  = 8'd2;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_DRIVE      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_COAST      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BRAKE      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TICK       = 3'd3;
   localparam logic [KIND_W-1:0] KIND_COAST_ALL  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_BRAKE_ALL  = 3'd5;

   // valid motor numbers
   localparam logic [MOTOR_W-1:0] MOTOR_ONE = 8'd1;
   localparam logic [MOTOR_W-1:0] MOTOR_TWO = 8'd2;

   // full-scale duty
   localparam logic [MAG_W-1:0] DUTY_FULL = 10'd1000;

   // scaling: product (period+1)*duty fits 26 bits; divide by 1000 as
   // a shift by 3 then a reciprocal multiply for division by 125
   localparam int PROD_W      = 26;
   localparam int PRE_SHIFT   = 3;
   localparam int DIVIN_W     = PROD_W - PRE_SHIFT;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;
   localparam int QFULL_W     = DIVIN_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;

   // input item
   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [MOTOR_W-1:0]        motor;
      logic signed [VALUE_W-1:0] drive_value;
      logic [TIME_W-1:0]         now_ms;
   } req_type;

   // result item
   typedef struct packed {
      logic             m1_pin_a;
      logic             m1_pin_b;
      logic [CMP_W-1:0] m1_compare;
      logic             m2_pin_a;
      logic             m2_pin_b;
      logic [CMP_W-1:0] m2_compare;
      logic             m1_reversal_waiting;
      logic             m2_reversal_waiting;
   } rsp_type;

   // command for one motor slice
   typedef struct packed {
      logic               drive;
      logic               coast;
      logic               brake;
      logic               tick;
      logic [VALUE_W-1:0] value;
      logic [TIME_W-1:0]  now;
   } motor_cmd_type;

   // status from one motor slice, pins in motor-one convention {b, a}
   typedef struct packed {
      logic [1:0]       pins;
      logic             waiting;
      logic             cmp_update;
      logic [MAG_W-1:0] mag;
   } motor_out_type;

endpackage

`default_nettype wire

@@ rtl/core/dhb_motor.sv @@
// per-motor direction memory, reversal queue and dead-time interlock
`default_nettype none

module dhb_motor
   import dhb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  motor_cmd_type       cmd,
   input  logic [DEAD_W-1:0]   dead_time,
   output motor_out_type       status
);

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   localparam logic [1:0] PINS_COAST = 2'b00;
   localparam logic [1:0] PINS_BRAKE = 2'b11;
   localparam logic [1:0] PINS_FWD   = 2'b01;
   localparam logic [1:0] PINS_REV   = 2'b10;

   dir_type            dir_ff, dir_in;
   logic [VALUE_W-1:0] queued_ff, queued_in;
   logic [TIME_W-1:0]  deadline_ff, deadline_in;
   logic               waiting_ff, waiting_in;
   logic [1:0]         pins_ff, pins_in;

   logic               fire;
   logic               do_drive;
   logic               drive_apply;
   logic [VALUE_W-1:0] drv_value;
   logic               neg;
   dir_type            dir_new;
   dir_type            dir_cur;
   logic [CMP_W-1:0]   abs_value;
   logic [MAG_W-1:0]   mag;
   logic [TIME_W-1:0]  since;
   logic               cmp_update;

   // queued reversal is due once the deadline is not in the future
   assign since    = cmd.now - deadline_ff;
   assign fire     = cmd.tick && waiting_ff && !since[TIME_W-1];
   assign do_drive = cmd.drive || fire;
   assign drv_value = fire ? queued_ff : cmd.value;
   assign neg      = drv_value[VALUE_W-1];
   assign dir_new  = neg ? DIR_REV : DIR_FWD;
   assign dir_cur  = fire ? DIR_NONE : dir_ff;

   // magnitude clamped to full-scale duty
   always_comb begin
      abs_value = neg ? (CMP_W'(17'h10000) - CMP_W'(drv_value)) : CMP_W'(drv_value);
      if (abs_value > CMP_W'(DUTY_FULL)) begin
         mag = DUTY_FULL;
      end else begin
         mag = abs_value[MAG_W-1:0];
      end
   end

   // next state for this item
   always_comb begin
      dir_in      = dir_ff;
      queued_in   = queued_ff;
      deadline_in = deadline_ff;
      waiting_in  = waiting_ff;
      pins_in     = pins_ff;
      cmp_update  = 1'b0;
      drive_apply = 1'b0;
      if (cmd.coast) begin
         pins_in    = PINS_COAST;
         cmp_update = 1'b1;
      end else if (cmd.brake) begin
         pins_in    = PINS_BRAKE;
         cmp_update = 1'b1;
      end else if (do_drive) begin
         if (fire) begin
            waiting_in = 1'b0;
            dir_in     = DIR_NONE;
         end
         if (drv_value == '0) begin
            pins_in    = PINS_COAST;
            cmp_update = 1'b1;
         end else if (dir_cur != DIR_NONE && dir_cur != dir_new) begin
            // reversal: coast now, apply after the dead time
            pins_in     = PINS_COAST;
            cmp_update  = 1'b1;
            queued_in   = drv_value;
            deadline_in = cmd.now + TIME_W'(dead_time);
            waiting_in  = 1'b1;
         end else begin
            waiting_in  = 1'b0;
            dir_in      = dir_new;
            pins_in     = neg ? PINS_REV : PINS_FWD;
            cmp_update  = 1'b1;
            drive_apply = 1'b1;
         end
      end
   end

   // status follows the state after this item
   always_comb begin
      status.pins       = pins_in;
      status.waiting    = waiting_in;
      status.cmp_update = cmp_update;
      status.mag        = drive_apply ? mag : '0;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff      <= DIR_NONE;
         queued_ff   <= '0;
         deadline_ff <= '0;
         waiting_ff  <= 1'b0;
         pins_ff     <= PINS_COAST;
      end else if (step) begin
         dir_ff      <= dir_in;
         queued_ff   <= queued_in;
         deadline_ff <= deadline_in;
         waiting_ff  <= waiting_in;
         pins_ff     <= pins_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/dual_hbridge_reversal_deadtime.sv @@
// top level of the dual h-bridge drive with reversal dead-time interlock
`default_nettype none

// Takes one command transfer per clock while the result side is not stalled,
// and returns one result transfer per command through the input, middle and
// result registers. The first stage decodes the command and updates each
// motor's direction memory, queued reversal and pin levels, and multiplies
// (pwm_period+1) by the clamped duty; the second divides that product by 1000
// through a reciprocal multiply; the result register then holds both motors'
// pins, compare values and waiting flags. The two multipliers set the depth of
// the pipeline; a stall on the result side holds every stage. Compare values
// are computed with the period in force when the drive is applied.

module dual_hbridge_reversal_deadtime
   import dhb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef struct packed {
      logic              pin_a;
      logic              pin_b;
      logic              waiting;
      logic              cmp_update;
      logic [PROD_W-1:0] prod;
   } mid_type;

   logic [PERIOD_W-1:0] period_ff;
   logic [DEAD_W-1:0]   dead_ff;
   logic                in_valid_ff;
   req_type             in_ff;
   logic                mid_valid_ff;
   mid_type             mid_ff [2];
   mid_type             mid_in [2];
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   logic                adv;
   logic                motor_ok;
   logic                motor_sel;
   motor_cmd_type       cmd [2];
   motor_out_type       status [2];
   logic [CMP_W-1:0]    period_p1;
   logic [CMP_W-1:0]    quot [2];

   // pipeline moves unless a finished result is held by the receiver
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PWM_PERIOD_RESET;
         dead_ff   <= DEAD_TIME_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PWM_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_DEAD_TIME:  dead_ff   <= csr_wdata[DEAD_W-1:0];
            default: ;
         endcase
      end
   end

   // command decode into per-motor commands
   assign motor_ok  = (in_ff.motor == MOTOR_ONE) || (in_ff.motor == MOTOR_TWO);
   assign motor_sel = (in_ff.motor == MOTOR_TWO);

   always_comb begin
      for (int m = 0; m < 2; m++) begin
         cmd[m].drive = 1'b0;
         cmd[m].coast = 1'b0;
         cmd[m].brake = 1'b0;
         cmd[m].tick  = 1'b0;
         cmd[m].value = in_ff.drive_value;
         cmd[m].now   = in_ff.now_ms;
      end
      unique case (in_ff.kind)
         KIND_DRIVE: if (motor_ok) begin
            cmd[motor_sel].drive = 1'b1;
         end
         KIND_COAST: if (motor_ok) begin
            cmd[motor_sel].coast = 1'b1;
         end
         KIND_BRAKE: if (motor_ok) begin
            cmd[motor_sel].brake = 1'b1;
         end
         KIND_TICK: begin
            cmd[0].tick = 1'b1;
            cmd[1].tick = 1'b1;
         end
         KIND_COAST_ALL: begin
            cmd[0].coast = 1'b1;
            cmd[1].coast = 1'b1;
         end
         KIND_BRAKE_ALL: begin
            cmd[0].brake = 1'b1;
            cmd[1].brake = 1'b1;
         end
         default: ;
      endcase
   end

   // motor slices
   dhb_motor u_motor1 (
      .clock     (clock),
      .reset     (reset),
      .step      (adv && in_valid_ff),
      .cmd       (cmd[0]),
      .dead_time (dead_ff),
      .status    (status[0])
   );

   dhb_motor u_motor2 (
      .clock     (clock),
      .reset     (reset),
      .step      (adv && in_valid_ff),
      .cmd       (cmd[1]),
      .dead_time (dead_ff),
      .status    (status[1])
   );

   // first scaling stage: (period+1) * duty, motor two pins mirrored
   assign period_p1 = CMP_W'(period_ff) + CMP_W'(1);

   always_comb begin
      for (int m = 0; m < 2; m++) begin
         mid_in[m].pin_a      = (m == 0) ? status[m].pins[0] : status[m].pins[1];
         mid_in[m].pin_b      = (m == 0) ? status[m].pins[1] : status[m].pins[0];
         mid_in[m].waiting    = status[m].waiting;
         mid_in[m].cmp_update = status[m].cmp_update;
         mid_in[m].prod       = PROD_W'(period_p1) * PROD_W'(status[m].mag);
      end
   end

   // second scaling stage: divide by 1000, keep old compare when untouched
   always_comb begin
      for (int m = 0; m < 2; m++) begin
         quot[m] = CMP_W'((QFULL_W'(mid_ff[m].prod[PROD_W-1:PRE_SHIFT]) *
                           QFULL_W'(RECIP_125)) >> RECIP_SHIFT);
      end
      rsp_in.m1_pin_a            = mid_ff[0].pin_a;
      rsp_in.m1_pin_b            = mid_ff[0].pin_b;
      rsp_in.m1_compare          = mid_ff[0].cmp_update ? quot[0] : rsp_ff.m1_compare;
      rsp_in.m2_pin_a            = mid_ff[1].pin_a;
      rsp_in.m2_pin_b            = mid_ff[1].pin_b;
      rsp_in.m2_compare          = mid_ff[1].cmp_update ? quot[1] : rsp_ff.m2_compare;
      rsp_in.m1_reversal_waiting = mid_ff[0].waiting;
      rsp_in.m2_reversal_waiting = mid_ff[1].waiting;
   end

   // stage valids and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else if (adv) begin
         in_valid_ff  <= req_valid;
         mid_valid_ff <= in_valid_ff;
         rsp_valid_ff <= mid_valid_ff;
         if (mid_valid_ff) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         if (req_valid) begin
            in_ff <= req_data;
         end
         if (in_valid_ff) begin
            mid_ff[0] <= mid_in[0];
            mid_ff[1] <= mid_in[1];
         end
      end
   end

endmodule

`default_nettype wire
